FILE: rtl/core/complex_matrix_product_macros.svh
// Assertion macros used by the complex matrix product top level.
`ifndef COMPLEX_MATRIX_PRODUCT_MACROS_SVH
`define COMPLEX_MATRIX_PRODUCT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CMP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_matrix_product: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_matrix_product: next-cycle check failed");

`endif

FILE: rtl/core/cmp_pkg.sv
// Package with the types and constants of the complex matrix product.
`timescale 1ns / 1ps

package cmp_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 30;

    typedef struct packed {
        logic [3:0]               elem_index;
        logic signed [DATA_W-1:0] left_re;
        logic signed [DATA_W-1:0] left_im;
        logic signed [DATA_W-1:0] right_re;
        logic signed [DATA_W-1:0] right_im;
        logic                     load_last;
    } in_t;

    typedef struct packed {
        logic [1:0]               out_row;
        logic [1:0]               out_col;
        logic signed [DATA_W-1:0] prod_re;
        logic signed [DATA_W-1:0] prod_im;
        logic                     saturated;
        logic                     out_last;
    } out_t;

    typedef struct packed {
        logic       valid;
        logic       first_term;
        logic       last_term;
        logic       last_elem;
        logic [1:0] row;
        logic [1:0] col;
    } tag_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

endpackage

FILE: rtl/core/cmp_mac.sv
// Complex multiply-accumulate unit with truncation and saturation of each product element.
`timescale 1ns / 1ps

module cmp_mac #(
    parameter int DIM = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cmp_pkg::tag_t                      tag,
    input  logic [2*cmp_pkg::DATA_W-1:0]       left_data,
    input  logic [2*cmp_pkg::DATA_W-1:0]       right_data,
    output logic                               fin,
    output logic                               result_valid,
    output cmp_pkg::out_t                      result
);
    import cmp_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + $clog2(4 * DIM) + 1;
    localparam int SHR_W  = ACC_W - FRAC_W;

    logic signed [DATA_W-1:0] ar, ai, br, bi;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    tag_t                     tag2_reg, tag3_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next, acc_im_next;
    logic signed [ACC_W-1:0]  base_re, base_im;
    logic signed [SHR_W-1:0]  shr_re, shr_im;
    logic                     clip_re, clip_im;
    logic signed [DATA_W-1:0] sat_re, sat_im;
    logic                     result_valid_reg;
    out_t                     result_reg, result_next;

    assign ar = $signed(left_data[2*DATA_W-1:DATA_W]);
    assign ai = $signed(left_data[DATA_W-1:0]);
    assign br = $signed(right_data[2*DATA_W-1:DATA_W]);
    assign bi = $signed(right_data[DATA_W-1:0]);

    always_ff @(posedge clk)
    begin
        p_rr_reg <= ar * br;
        p_ii_reg <= ai * bi;
        p_ri_reg <= ar * bi;
        p_ir_reg <= ai * br;
    end

    always_comb
    begin
        base_re     = tag2_reg.first_term ? '0 : acc_re_reg;
        base_im     = tag2_reg.first_term ? '0 : acc_im_reg;
        acc_re_next = base_re + ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg);
        acc_im_next = base_im + ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg);
    end

    always_ff @(posedge clk)
    begin
        if (tag2_reg.valid)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    always_comb
    begin
        shr_re  = SHR_W'(acc_re_reg >>> FRAC_W);
        shr_im  = SHR_W'(acc_im_reg >>> FRAC_W);
        clip_re = !((&shr_re[SHR_W-1:DATA_W-1]) || !(|shr_re[SHR_W-1:DATA_W-1]));
        clip_im = !((&shr_im[SHR_W-1:DATA_W-1]) || !(|shr_im[SHR_W-1:DATA_W-1]));
        sat_re  = clip_re ? {shr_re[SHR_W-1], {(DATA_W-1){!shr_re[SHR_W-1]}}}
                          : shr_re[DATA_W-1:0];
        sat_im  = clip_im ? {shr_im[SHR_W-1], {(DATA_W-1){!shr_im[SHR_W-1]}}}
                          : shr_im[DATA_W-1:0];
        fin     = tag3_reg.valid && tag3_reg.last_term && tag3_reg.last_elem;

        result_next.out_row   = tag3_reg.row;
        result_next.out_col   = tag3_reg.col;
        result_next.prod_re   = sat_re;
        result_next.prod_im   = sat_im;
        result_next.saturated = clip_re || clip_im;
        result_next.out_last  = tag3_reg.last_elem;
    end

    always_ff @(posedge clk)
    begin
        if (tag3_reg.valid && tag3_reg.last_term)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg         <= '0;
            tag3_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tag2_reg         <= tag;
            tag3_reg         <= tag2_reg;
            result_valid_reg <= tag3_reg.valid && tag3_reg.last_term;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/core/complex_matrix_product.sv
// Top level of the complex matrix product: element stores, sequencer and MAC unit.
//
//  Channel   Signals                      Handshake
//  request   start, busy, request         taken when start is high and busy is low
//  result    result_valid, result         shown for one cycle, cannot be held off
//
// An item without load_last only writes the element stores.
// The item with load_last keeps busy high until the last result: the sequencer
// reads one left and one right element per cycle and the MAC unit does one complex
// multiply-accumulate per cycle. A result appears after every DIM terms.
// Reset clears the sequencer and pipeline valid bits; the stores are not cleared.
// busy drops in the cycle the last result is shown, so the next request can be taken.
`timescale 1ns / 1ps

module complex_matrix_product #(
    parameter int DIM = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cmp_pkg::in_t  request,
    output logic          result_valid,
    output cmp_pkg::out_t result
);
    import cmp_pkg::*;

    localparam int NUM_ELEMS = DIM * DIM;
    localparam int AW        = $clog2(NUM_ELEMS);
    localparam int CW        = $clog2(DIM);
    localparam int EW        = 2 * DATA_W;

    logic [EW-1:0] left_mem  [NUM_ELEMS];
    logic [EW-1:0] right_mem [NUM_ELEMS];
    logic [EW-1:0] left_rd_reg, right_rd_reg;

    seq_state_t    state_reg, state_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic [CW-1:0] i_next, j_next, k_next;
    tag_t          tag_reg, tag_next;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] left_addr, right_addr;
    logic          k_end, j_end, i_end;
    logic          fin;

    assign accept     = start && !busy_reg;
    assign wr_en      = accept && (32'(request.elem_index) < NUM_ELEMS);
    assign wr_addr    = AW'(request.elem_index);
    assign left_addr  = AW'(int'(i_reg) * DIM + int'(k_reg));
    assign right_addr = AW'(int'(k_reg) * DIM + int'(j_reg));
    assign k_end      = (k_reg == CW'(DIM - 1));
    assign j_end      = (j_reg == CW'(DIM - 1));
    assign i_end      = (i_reg == CW'(DIM - 1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= {request.left_re, request.left_im};
            right_mem[wr_addr] <= {request.right_re, request.right_im};
        end
        left_rd_reg  <= left_mem[left_addr];
        right_rd_reg <= right_mem[right_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        tag_next   = '0;

        if (accept && request.load_last)
        begin
            busy_next = 1'b1;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
        end

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (accept && request.load_last)
                begin
                    state_next = SEQ_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            SEQ_RUN:
            begin
                tag_next.valid      = 1'b1;
                tag_next.first_term = (k_reg == '0);
                tag_next.last_term  = k_end;
                tag_next.last_elem  = i_end && j_end;
                tag_next.row        = 2'(i_reg);
                tag_next.col        = 2'(j_reg);
                k_next              = k_end ? '0 : k_reg + 1'b1;
                if (k_end)
                begin
                    j_next = j_end ? '0 : j_reg + 1'b1;
                    if (j_end)
                    begin
                        i_next = i_end ? '0 : i_reg + 1'b1;
                        if (i_end)
                        begin
                            state_next = SEQ_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            busy_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            tag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            tag_reg   <= tag_next;
        end
    end

    cmp_mac #(
        .DIM(DIM)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .tag          (tag_reg),
        .left_data    (left_rd_reg),
        .right_data   (right_rd_reg),
        .fin          (fin),
        .result_valid (result_valid),
        .result       (result)
    );

    assign busy = busy_reg;

`include "complex_matrix_product_macros.svh"

    `CMP_ASSERT_SAME(a_run_is_busy, state_reg == SEQ_RUN, busy_reg)
    `CMP_ASSERT_SAME(a_last_frees, result_valid && result.out_last, !busy_reg)
    `CMP_ASSERT_SAME(a_mid_busy, result_valid && !result.out_last, busy_reg)
    `CMP_ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid)
    `CMP_ASSERT_NEXT(a_fin_drops, fin, !busy_reg)

endmodule

FILE: tb/sv/complex_matrix_product_tb.sv
// Self-checking testbench for the complex matrix product: directed and random loads, predicted products.
`timescale 1ns / 1ps

module complex_matrix_product_tb;
    import cmp_pkg::*;

    localparam int DIM       = 3;
    localparam int NUM_ELEMS = DIM * DIM;
    localparam int NUM_ITEMS = 160;
    localparam int DRAIN     = DIM * DIM * DIM + 12;
    localparam int LIMIT     = 200000;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh40000000;

    class matrix_product_checker;
        logic signed [DATA_W-1:0] left_re_mem[NUM_ELEMS];
        logic signed [DATA_W-1:0] left_im_mem[NUM_ELEMS];
        logic signed [DATA_W-1:0] right_re_mem[NUM_ELEMS];
        logic signed [DATA_W-1:0] right_im_mem[NUM_ELEMS];
        out_t expected_elems[$];
        int   error_count;
        int   checked_count;
        int   sat_count;
        int   product_count;

        function new();
            error_count   = 0;
            checked_count = 0;
            sat_count     = 0;
            product_count = 0;
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            error_count++;
        endtask

        function logic signed [DATA_W-1:0] clip_part(logic signed [127:0] v, inout bit clip);
            if (v > 128'sd2147483647) begin
                clip = 1'b1;
                return Q_MAX;
            end
            if (v < -128'sd2147483648) begin
                clip = 1'b1;
                return Q_MIN;
            end
            return v[DATA_W-1:0];
        endfunction

        function void note_request(in_t r);
            logic signed [127:0] acc_re;
            logic signed [127:0] acc_im;
            logic signed [127:0] ar;
            logic signed [127:0] ai;
            logic signed [127:0] br;
            logic signed [127:0] bi;
            bit   clip;
            out_t elem;
            if (r.elem_index < NUM_ELEMS) begin
                left_re_mem[r.elem_index]  = r.left_re;
                left_im_mem[r.elem_index]  = r.left_im;
                right_re_mem[r.elem_index] = r.right_re;
                right_im_mem[r.elem_index] = r.right_im;
            end
            if (!r.load_last)
                return;
            product_count++;
            for (int i = 0; i < DIM; i++) begin
                for (int j = 0; j < DIM; j++) begin
                    acc_re = '0;
                    acc_im = '0;
                    for (int k = 0; k < DIM; k++) begin
                        ar = left_re_mem[i * DIM + k];
                        ai = left_im_mem[i * DIM + k];
                        br = right_re_mem[k * DIM + j];
                        bi = right_im_mem[k * DIM + j];
                        acc_re = acc_re + ar * br - ai * bi;
                        acc_im = acc_im + ar * bi + ai * br;
                    end
                    clip           = 1'b0;
                    elem.out_row   = 2'(i);
                    elem.out_col   = 2'(j);
                    elem.prod_re   = clip_part(acc_re >>> FRAC_W, clip);
                    elem.prod_im   = clip_part(acc_im >>> FRAC_W, clip);
                    elem.saturated = clip;
                    elem.out_last  = (i == DIM - 1) && (j == DIM - 1);
                    expected_elems.push_back(elem);
                end
            end
        endfunction

        task check_result(out_t got);
            out_t want;
            if (expected_elems.size() == 0) begin
                report_mismatch($sformatf("unexpected result row %0d col %0d",
                                          got.out_row, got.out_col));
                return;
            end
            want = expected_elems.pop_front();
            checked_count++;
            if (want.saturated)
                sat_count++;
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
            if (got.out_col !== want.out_col)
                report_mismatch($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
            if (got.prod_re !== want.prod_re)
                report_mismatch($sformatf("prod_re %0d, expected %0d at (%0d,%0d)",
                                          got.prod_re, want.prod_re, want.out_row, want.out_col));
            if (got.prod_im !== want.prod_im)
                report_mismatch($sformatf("prod_im %0d, expected %0d at (%0d,%0d)",
                                          got.prod_im, want.prod_im, want.out_row, want.out_col));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated %0b, expected %0b at (%0d,%0d)",
                                          got.saturated, want.saturated,
                                          want.out_row, want.out_col));
            if (got.out_last !== want.out_last)
                report_mismatch($sformatf("out_last %0b, expected %0b at (%0d,%0d)",
                                          got.out_last, want.out_last,
                                          want.out_row, want.out_col));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  request;
    logic result_valid;
    out_t result;

    matrix_product_checker sb;
    int cycle_count;
    int sent_count;

    complex_matrix_product #(
        .DIM(DIM)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    function automatic in_t make_req(int idx, logic signed [DATA_W-1:0] lre,
                                     logic signed [DATA_W-1:0] lim,
                                     logic signed [DATA_W-1:0] rre,
                                     logic signed [DATA_W-1:0] rim, bit last);
        in_t r;
        r.elem_index = 4'(idx);
        r.left_re    = lre;
        r.left_im    = lim;
        r.right_re   = rre;
        r.right_im   = rim;
        r.load_last  = last;
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_part();
        int v;
        case ($urandom_range(9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return '0;
            3: return -1;
            4: return Q_ONE;
            5, 6:
            begin
                v = int'($urandom_range(0, 536870911)) - 268435456;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic in_t rand_req(int idx, bit last);
        return make_req(idx, rand_part(), rand_part(), rand_part(), rand_part(), last);
    endfunction

    task automatic send_request(in_t r);
        int gap;
        bit quiet;
        quiet = (sent_count >= 70) && (sent_count < 120);
        if (!quiet && $urandom_range(99) < 6)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    initial
    begin
        int order[NUM_ELEMS];
        int kind;
        int n;
        int j;
        int tmp;
        sb          = new();
        cycle_count = 0;
        sent_count  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale negative and positive matrices saturate the imaginary part; real parts cancel.
        for (int e = 0; e < NUM_ELEMS; e++)
            send_request(make_req(e, Q_MIN, Q_MIN, Q_MIN, Q_MIN, e == NUM_ELEMS - 1));
        for (int e = NUM_ELEMS - 1; e >= 0; e--)
            send_request(make_req(e, Q_MAX, Q_MAX, Q_MAX, Q_MAX, e == 0));
        // Out-of-range indexes are ignored, but load_last still starts a product.
        send_request(make_req(9, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0));
        send_request(make_req(15, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1));
        // The element on the load_last request is written before the product.
        send_request(make_req(4, -1, Q_ONE, Q_ONE, -1, 1'b1));
        send_request(make_req(NUM_ELEMS - 1, '0, '0, '0, '0, 1'b1));

        while (sent_count < NUM_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                for (int e = 0; e < NUM_ELEMS; e++)
                    order[e] = e;
                for (int e = NUM_ELEMS - 1; e > 0; e--)
                begin
                    j        = $urandom_range(e);
                    tmp      = order[e];
                    order[e] = order[j];
                    order[j] = tmp;
                end
                for (int e = 0; e < NUM_ELEMS; e++)
                    send_request(rand_req(order[e], e == NUM_ELEMS - 1));
            end
            else if (kind < 85)
            begin
                n = $urandom_range(1, 4);
                for (int e = 0; e < n; e++)
                    send_request(rand_req($urandom_range(NUM_ELEMS - 1), e == n - 1));
            end
            else
                send_request(rand_req($urandom_range(NUM_ELEMS, 15), $urandom_range(1)));
        end

        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_elems.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (sb.expected_elems.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never arrived",
                                         sb.expected_elems.size()));

        $display("Run covered %0d requests and %0d products, with extremes, out-of-range indexes",
                 sent_count, sb.product_count);
        $display("and partial reloads; %0d result elements checked, %0d of them saturated.",
                 sb.checked_count, sb.sat_count);
        if (sb.error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
